### src/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int PIX_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd3;

  localparam logic [1:0] LAST_BEAT = 2'd3;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_REG1 = 2'd1,
    PH_REG2 = 2'd2
  } mer_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RST_A,
    ST_RST_B,
    ST_RST_C,
    ST_RST_D,
    ST_EMIT,
    ST_FIN,
    ST_ADV,
    ST_CHK,
    ST_SW_A,
    ST_SW_B,
    ST_SW_C,
    ST_SW_D,
    ST_SW_E,
    ST_SW_F
  } mer_state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_RXRX,
    OP_MUL_RYRY,
    OP_MUL_RX2RY,
    OP_START,
    OP_EMIT,
    OP_FIN,
    OP_ADV,
    OP_MUL_TXTX,
    OP_MUL_RY2P,
    OP_MUL_TYTY,
    OP_MUL_RX2P,
    OP_MUL_RX2RY2,
    OP_SET_DEC
  } mer_op_e;

  typedef struct packed {
    mer_op_e    op;
    logic [1:0] beat;
  } mer_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       y_zero;
    logic       slope_ge;
    mer_phase_e phase;
  } mer_sts_t;

endpackage

`default_nettype wire

### src/mer_ctrl.sv
// Sequencer for restart, pixel beats, midpoint advance and region switch.
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              restart_i,
  output logic                   in_stall_o,
  input  wire mer_pkg::mer_sts_t sts_i,
  output mer_pkg::mer_cmd_t      cmd_o
);

  mer_pkg::mer_state_e state_q, state_d;
  logic [1:0]          beat_q, beat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mer_pkg::ST_IDLE;
      beat_q  <= '0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
    end
  end

  always_comb begin
    state_d = state_q;
    beat_d  = beat_q;
    case (state_q)
      mer_pkg::ST_IDLE: begin
        beat_d = '0;
        if (in_valid_i) begin
          if (restart_i) begin
            state_d = mer_pkg::ST_RST_A;
          end else if (sts_i.phase == mer_pkg::PH_DONE) begin
            state_d = mer_pkg::ST_FIN;
          end else begin
            state_d = mer_pkg::ST_EMIT;
          end
        end
      end
      mer_pkg::ST_RST_A: state_d = mer_pkg::ST_RST_B;
      mer_pkg::ST_RST_B: state_d = mer_pkg::ST_RST_C;
      mer_pkg::ST_RST_C: state_d = mer_pkg::ST_RST_D;
      mer_pkg::ST_RST_D: state_d = mer_pkg::ST_EMIT;
      mer_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          beat_d = beat_q + 2'd1;
          if (beat_q == mer_pkg::LAST_BEAT) begin
            state_d = sts_i.y_zero ? mer_pkg::ST_IDLE : mer_pkg::ST_ADV;
          end
        end
      end
      mer_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = mer_pkg::ST_IDLE;
        end
      end
      mer_pkg::ST_ADV: begin
        state_d = (sts_i.phase == mer_pkg::PH_REG1) ? mer_pkg::ST_CHK : mer_pkg::ST_IDLE;
      end
      mer_pkg::ST_CHK: begin
        state_d = sts_i.slope_ge ? mer_pkg::ST_SW_A : mer_pkg::ST_IDLE;
      end
      mer_pkg::ST_SW_A: state_d = mer_pkg::ST_SW_B;
      mer_pkg::ST_SW_B: state_d = mer_pkg::ST_SW_C;
      mer_pkg::ST_SW_C: state_d = mer_pkg::ST_SW_D;
      mer_pkg::ST_SW_D: state_d = mer_pkg::ST_SW_E;
      mer_pkg::ST_SW_E: state_d = mer_pkg::ST_SW_F;
      mer_pkg::ST_SW_F: state_d = mer_pkg::ST_IDLE;
      default:          state_d = mer_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != mer_pkg::ST_IDLE);
    cmd_o.beat = beat_q;
    case (state_q)
      mer_pkg::ST_RST_A: cmd_o.op = mer_pkg::OP_MUL_RXRX;
      mer_pkg::ST_RST_B: cmd_o.op = mer_pkg::OP_MUL_RYRY;
      mer_pkg::ST_RST_C: cmd_o.op = mer_pkg::OP_MUL_RX2RY;
      mer_pkg::ST_RST_D: cmd_o.op = mer_pkg::OP_START;
      mer_pkg::ST_EMIT:  cmd_o.op = mer_pkg::OP_EMIT;
      mer_pkg::ST_FIN:   cmd_o.op = mer_pkg::OP_FIN;
      mer_pkg::ST_ADV:   cmd_o.op = mer_pkg::OP_ADV;
      mer_pkg::ST_SW_A:  cmd_o.op = mer_pkg::OP_MUL_TXTX;
      mer_pkg::ST_SW_B:  cmd_o.op = mer_pkg::OP_MUL_RY2P;
      mer_pkg::ST_SW_C:  cmd_o.op = mer_pkg::OP_MUL_TYTY;
      mer_pkg::ST_SW_D:  cmd_o.op = mer_pkg::OP_MUL_RX2P;
      mer_pkg::ST_SW_E:  cmd_o.op = mer_pkg::OP_MUL_RX2RY2;
      mer_pkg::ST_SW_F:  cmd_o.op = mer_pkg::OP_SET_DEC;
      default:           cmd_o.op = mer_pkg::OP_NOP;
    endcase
  end

`ifndef SYNTHESIS
  a_restart_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mer_pkg::ST_IDLE && in_valid_i && restart_i) |=> state_q == mer_pkg::ST_RST_A)
    else $error("restart beat did not start the radius sequence");
  a_done_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mer_pkg::ST_IDLE && in_valid_i && !restart_i &&
     sts_i.phase == mer_pkg::PH_DONE) |=> state_q == mer_pkg::ST_FIN)
    else $error("step without active ellipse did not report finished");
  a_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mer_pkg::ST_EMIT && !sts_i.out_free) |=> $stable(beat_q))
    else $error("pixel beat index moved while output was blocked");
`endif

endmodule

`default_nettype wire

### src/mer_datapath.sv
// Registers, shared multiplier, midpoint update and output register.
`timescale 1ns / 1ps
`default_nettype none

module mer_datapath #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11,
  parameter int CFG_W       = 11
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mer_pkg::mer_cmd_t              cmd_i,
  output mer_pkg::mer_sts_t                   sts_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]               cfg_data_i,
  input  wire logic                           out_stall_i,
  output logic                                out_valid_o,
  output logic signed [mer_pkg::PIX_W-1:0]    pixel_x_o,
  output logic signed [mer_pkg::PIX_W-1:0]    pixel_y_o,
  output logic                                last_o,
  output logic                                finished_o
);

  localparam int R     = RADIUS_BITS;
  localparam int C     = COORD_BITS;
  localparam int SQ_W  = 2 * R;
  localparam int MA_W  = 2 * R;
  localparam int MB_W  = 2 * R + 2;
  localparam int P_W   = MA_W + MB_W;
  localparam int SL_W  = 3 * R + 2;
  localparam int DEC_W = 4 * R + 4;
  localparam int XW0   = (C > R) ? C : R;
  localparam int EXT_W = (XW0 > mer_pkg::PIX_W) ? XW0 : mer_pkg::PIX_W;
  localparam int PW    = mer_pkg::PIX_W;

  logic [C-1:0]             center_x_q, center_y_q;
  logic [R-1:0]             radius_x_q, radius_y_q;
  logic [R-1:0]             cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [SL_W-1:0]          slope_x_q, slope_x_d, slope_y_q, slope_y_d;
  logic signed [DEC_W-1:0]  dec_q, dec_d, acc_q, acc_d;
  mer_pkg::mer_phase_e      phase_q, phase_d;
  logic [SQ_W-1:0]          rx2_q, rx2_d, ry2_q, ry2_d;
  logic [P_W-1:0]           p_q, p_d;
  logic [MA_W-1:0]          mul_a;
  logic [MB_W-1:0]          mul_b;

  logic                     out_valid_q, out_valid_d;
  logic [PW-1:0]            pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic                     last_q, last_d, fin_q, fin_d;
  logic                     out_free, load;

  logic [SL_W-1:0]          sx_n, sy_n;
  logic signed [DEC_W-1:0]  sx_n_e, sy_n_e, rx2_e, ry2_e, p_e;
  logic [R-1:0]             ty_abs;
  logic [EXT_W-1:0]         xp, xm, yp, ym;
  logic                     x_plus, y_plus, dec_neg, dec_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= C'(200);
      center_y_q <= C'(200);
      radius_x_q <= R'(150);
      radius_y_q <= R'(50);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mer_pkg::REG_CENTER_X: center_x_q <= cfg_data_i[C-1:0];
        mer_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i[C-1:0];
        mer_pkg::REG_RADIUS_X: radius_x_q <= cfg_data_i[R-1:0];
        mer_pkg::REG_RADIUS_Y: radius_y_q <= cfg_data_i[R-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mer_pkg::PH_DONE;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      slope_x_q   <= '0;
      slope_y_q   <= '0;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      slope_x_q   <= slope_x_d;
      slope_y_q   <= slope_y_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    acc_q   <= acc_d;
    rx2_q   <= rx2_d;
    ry2_q   <= ry2_d;
    pix_x_q <= pix_x_d;
    pix_y_q <= pix_y_d;
    last_q  <= last_d;
    fin_q   <= fin_d;
  end

  // Shared multiplier operands
  assign ty_abs = (cur_y_q == '0) ? R'(1) : (cur_y_q - R'(1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      mer_pkg::OP_MUL_RXRX: begin
        mul_a = MA_W'(radius_x_q);
        mul_b = MB_W'(radius_x_q);
      end
      mer_pkg::OP_MUL_RYRY: begin
        mul_a = MA_W'(radius_y_q);
        mul_b = MB_W'(radius_y_q);
      end
      mer_pkg::OP_MUL_RX2RY: begin
        mul_a = rx2_q;
        mul_b = MB_W'(radius_y_q);
      end
      mer_pkg::OP_MUL_TXTX: begin
        mul_a = MA_W'({cur_x_q, 1'b1});
        mul_b = MB_W'({cur_x_q, 1'b1});
      end
      mer_pkg::OP_MUL_RY2P: begin
        mul_a = ry2_q;
        mul_b = p_q[MB_W-1:0];
      end
      mer_pkg::OP_MUL_TYTY: begin
        mul_a = MA_W'(ty_abs);
        mul_b = MB_W'(ty_abs);
      end
      mer_pkg::OP_MUL_RX2P: begin
        mul_a = rx2_q;
        mul_b = p_q[MB_W-1:0];
      end
      mer_pkg::OP_MUL_RX2RY2: begin
        mul_a = rx2_q;
        mul_b = MB_W'(ry2_q);
      end
      default: ;
    endcase
  end

  assign p_d = mul_a * mul_b;

  assign rx2_e   = DEC_W'(rx2_q);
  assign ry2_e   = DEC_W'(ry2_q);
  assign p_e     = DEC_W'(p_q);
  assign dec_neg = dec_q[DEC_W-1];
  assign dec_pos = !dec_neg && (dec_q != '0);

  // Pixel coordinates of the current point
  assign xp     = EXT_W'(center_x_q) + EXT_W'(cur_x_q);
  assign xm     = EXT_W'(center_x_q) - EXT_W'(cur_x_q);
  assign yp     = EXT_W'(center_y_q) + EXT_W'(cur_y_q);
  assign ym     = EXT_W'(center_y_q) - EXT_W'(cur_y_q);
  assign x_plus = !cmd_i.beat[0];
  assign y_plus = (cmd_i.beat == 2'd0) || (cmd_i.beat == mer_pkg::LAST_BEAT);

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = out_free &&
                    (cmd_i.op == mer_pkg::OP_EMIT || cmd_i.op == mer_pkg::OP_FIN);

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    slope_x_d = slope_x_q;
    slope_y_d = slope_y_q;
    dec_d     = dec_q;
    acc_d     = acc_q;
    phase_d   = phase_q;
    rx2_d     = rx2_q;
    ry2_d     = ry2_q;
    sx_n      = slope_x_q + SL_W'({ry2_q, 1'b0});
    sy_n      = slope_y_q - SL_W'({rx2_q, 1'b0});
    sx_n_e    = DEC_W'(sx_n);
    sy_n_e    = DEC_W'(sy_n);
    case (cmd_i.op)
      mer_pkg::OP_MUL_RYRY: begin
        rx2_d = p_q[SQ_W-1:0];
      end
      mer_pkg::OP_MUL_RX2RY: begin
        ry2_d = p_q[SQ_W-1:0];
      end
      mer_pkg::OP_START: begin
        cur_x_d   = '0;
        cur_y_d   = radius_y_q;
        slope_x_d = '0;
        slope_y_d = {p_q[SL_W-2:0], 1'b0};
        dec_d     = (ry2_e <<< 2) - (p_e <<< 2) + rx2_e;
        phase_d   = mer_pkg::PH_REG1;
      end
      mer_pkg::OP_EMIT: begin
        if (out_free && cmd_i.beat == mer_pkg::LAST_BEAT && cur_y_q == '0) begin
          phase_d = mer_pkg::PH_DONE;
        end
      end
      mer_pkg::OP_ADV: begin
        if (phase_q == mer_pkg::PH_REG1) begin
          cur_x_d   = cur_x_q + R'(1);
          slope_x_d = sx_n;
          if (dec_neg) begin
            dec_d = dec_q + ((sx_n_e + ry2_e) <<< 2);
          end else begin
            cur_y_d   = cur_y_q - R'(1);
            slope_y_d = sy_n;
            dec_d     = dec_q + ((sx_n_e - sy_n_e + ry2_e) <<< 2);
          end
        end else begin
          cur_y_d   = cur_y_q - R'(1);
          slope_y_d = sy_n;
          if (dec_pos) begin
            dec_d = dec_q + ((rx2_e - sy_n_e) <<< 2);
          end else begin
            cur_x_d   = cur_x_q + R'(1);
            slope_x_d = sx_n;
            dec_d     = dec_q + ((sx_n_e - sy_n_e + rx2_e) <<< 2);
          end
        end
      end
      mer_pkg::OP_MUL_TYTY: begin
        acc_d = p_e;
      end
      mer_pkg::OP_MUL_RX2RY2: begin
        acc_d = acc_q + (p_e <<< 2);
      end
      mer_pkg::OP_SET_DEC: begin
        dec_d   = acc_q - (p_e <<< 2);
        phase_d = mer_pkg::PH_REG2;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    last_d      = last_q;
    fin_d       = fin_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (cmd_i.op == mer_pkg::OP_FIN) begin
        pix_x_d = '0;
        pix_y_d = '0;
        last_d  = 1'b1;
        fin_d   = 1'b1;
      end else begin
        pix_x_d = x_plus ? xp[PW-1:0] : xm[PW-1:0];
        pix_y_d = y_plus ? yp[PW-1:0] : ym[PW-1:0];
        last_d  = (cmd_i.beat == mer_pkg::LAST_BEAT);
        fin_d   = 1'b0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pix_x_q;
  assign pixel_y_o   = pix_y_q;
  assign last_o      = last_q;
  assign finished_o  = fin_q;

  assign sts_o.out_free = out_free;
  assign sts_o.y_zero   = (cur_y_q == '0);
  assign sts_o.slope_ge = (slope_x_q >= slope_y_q);
  assign sts_o.phase    = phase_q;

`ifndef SYNTHESIS
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fin_q) |-> (pix_x_q == '0 && pix_y_q == '0 && last_q))
    else $error("finished beat carries a pixel");
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mer_pkg::OP_EMIT && out_free && cmd_i.beat == mer_pkg::LAST_BEAT)
    |=> (out_valid_q && last_q && !fin_q))
    else $error("fourth pixel of a point not marked last");
  a_reg2_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mer_pkg::OP_ADV && phase_q == mer_pkg::PH_REG2)
    |=> (cur_y_q == $past(cur_y_q) - R'(1)))
    else $error("region 2 step did not lower y");
  a_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == mer_pkg::OP_SET_DEC) |=> (phase_q == mer_pkg::PH_REG2))
    else $error("decision reload did not enter region 2");
`endif

endmodule

`default_nettype wire

### src/midpoint_ellipse_rasterizer_top.sv
// Top level of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one step: restart loads the ellipse from the centre and
// radius registers and plots its first point, otherwise the current point is
// plotted and advanced. A plotting step gives four pixel beats, one per cycle
// while the output is not stalled, the fourth marked last; a step with no
// active ellipse gives one beat with finished set. Steps are handled one at a
// time: in region 1 a plotting step runs through an accept state, the four
// output beats, an update state and a slope compare before the next
// acceptance, and in region 2 it skips the slope compare; a stalled output
// holds the step. A restart first squares the radii on the shared multiplier;
// the step that crosses into region 2 then lets the same multiplier rebuild
// the decision term. Write the registers only while idle.
module midpoint_ellipse_rasterizer_top #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [mer_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   restart_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [mer_pkg::PIX_W-1:0]            pixel_x_o,
  output logic signed [mer_pkg::PIX_W-1:0]            pixel_y_o,
  output logic                                        last_o,
  output logic                                        finished_o
);

  localparam int CFG_W = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

  mer_pkg::mer_cmd_t cmd;
  mer_pkg::mer_sts_t sts;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS),
    .CFG_W       (CFG_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_o      (last_o),
    .finished_o  (finished_o)
  );

endmodule

`default_nettype wire

### verif/ellipse_checker.sv
// Scoreboard that predicts and checks the pixel beats of the ellipse rasterizer.
`timescale 1ns / 1ps

module ellipse_checker #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 11,
  parameter int CFG_W       = 11
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mer_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]                   cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               restart_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [mer_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic signed [mer_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic                               last_i,
  input  logic                               finished_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import mer_pkg::*;

  localparam int RST_CENTER   = 200;
  localparam int RST_RADIUS_X = 150;
  localparam int RST_RADIUS_Y = 50;
  localparam int REPORT_CAP   = 40;

  typedef struct packed {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic                    last;
    logic                    fin;
  } pixel_beat_t;

  logic [COORD_BITS-1:0]  ctr_x, ctr_y;
  logic [RADIUS_BITS-1:0] semi_x, semi_y;
  logic [RADIUS_BITS-1:0] pos_x, pos_y;
  logic [63:0]            run_x, run_y, dec_term;
  mer_phase_e             arc;
  pixel_beat_t            beat_q[$];

  task automatic report_mismatch(input string msg);
    if (fail_count_o < REPORT_CAP) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  task automatic trace_step(input logic restart);
    logic [63:0]      rx_sq, ry_sq, tx, ty;
    logic [PIX_W-1:0] xp, xm, yp, ym;
    rx_sq = 64'(semi_x) * 64'(semi_x);
    ry_sq = 64'(semi_y) * 64'(semi_y);
    if (restart) begin
      pos_x    = '0;
      pos_y    = semi_y;
      run_x    = '0;
      run_y    = 2 * rx_sq * 64'(pos_y);
      dec_term = 4 * ry_sq - 4 * rx_sq * 64'(semi_y) + rx_sq;
      arc      = PH_REG1;
    end
    if (arc != PH_REG1 && arc != PH_REG2) begin
      beat_q.push_back('{'0, '0, 1'b1, 1'b1});
      return;
    end
    xp = PIX_W'(ctr_x) + PIX_W'(pos_x);
    xm = PIX_W'(ctr_x) - PIX_W'(pos_x);
    yp = PIX_W'(ctr_y) + PIX_W'(pos_y);
    ym = PIX_W'(ctr_y) - PIX_W'(pos_y);
    beat_q.push_back('{xp, yp, 1'b0, 1'b0});
    beat_q.push_back('{xm, ym, 1'b0, 1'b0});
    beat_q.push_back('{xp, ym, 1'b0, 1'b0});
    beat_q.push_back('{xm, yp, 1'b1, 1'b0});
    if (pos_y == '0) begin
      arc = PH_DONE;
      return;
    end
    if (arc == PH_REG1) begin
      pos_x = pos_x + 1'b1;
      run_x = run_x + 2 * ry_sq;
      if (dec_term[63]) begin
        dec_term = dec_term + 4 * (run_x + ry_sq);
      end else begin
        pos_y    = pos_y - 1'b1;
        run_y    = run_y - 2 * rx_sq;
        dec_term = dec_term + 4 * (run_x - run_y + ry_sq);
      end
      if (run_x >= run_y) begin
        tx       = 2 * 64'(pos_x) + 1;
        ty       = 64'(pos_y) - 1;
        dec_term = ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq;
        arc      = PH_REG2;
      end
    end else begin
      pos_y = pos_y - 1'b1;
      run_y = run_y - 2 * rx_sq;
      if (!dec_term[63] && dec_term != 64'd0) begin
        dec_term = dec_term + 4 * (rx_sq - run_y);
      end else begin
        pos_x    = pos_x + 1'b1;
        run_x    = run_x + 2 * ry_sq;
        dec_term = dec_term + 4 * (run_x - run_y + rx_sq);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t want;
    if (!rst_ni) begin
      ctr_x     = COORD_BITS'(RST_CENTER);
      ctr_y     = COORD_BITS'(RST_CENTER);
      semi_x    = RADIUS_BITS'(RST_RADIUS_X);
      semi_y    = RADIUS_BITS'(RST_RADIUS_Y);
      pos_x     = '0;
      pos_y     = '0;
      run_x     = '0;
      run_y     = '0;
      dec_term  = '0;
      arc       = PH_DONE;
      beat_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (beat_q.size() == 0) begin
          report_mismatch($sformatf("unpredicted beat x=%0d y=%0d last=%b finished=%b",
                                    pixel_x_i, pixel_y_i, last_i, finished_i));
        end else begin
          want = beat_q.pop_front();
          if (pixel_x_i !== want.px || pixel_y_i !== want.py ||
              last_i !== want.last || finished_i !== want.fin) begin
            report_mismatch($sformatf(
              "got x=%0d y=%0d last=%b finished=%b, want x=%0d y=%0d last=%b finished=%b",
              pixel_x_i, pixel_y_i, last_i, finished_i,
              want.px, want.py, want.last, want.fin));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X: ctr_x  = cfg_data_i[COORD_BITS-1:0];
          REG_CENTER_Y: ctr_y  = cfg_data_i[COORD_BITS-1:0];
          REG_RADIUS_X: semi_x = cfg_data_i[RADIUS_BITS-1:0];
          REG_RADIUS_Y: semi_y = cfg_data_i[RADIUS_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        trace_step(restart_i);
      end
      pending_o = beat_q.size();
    end
  end

endmodule

### verif/testbench.sv
// Stimulus, pacing and verdict for the midpoint ellipse rasterizer regression.
`timescale 1ns / 1ps

module testbench;
  import mer_pkg::*;

  localparam int RADIUS_BITS   = 10;
  localparam int COORD_BITS    = 11;
  localparam int CFG_W         = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT    = 1000;
  localparam int ITEM_TARGET   = 120;
  localparam int STALL_WINDOW  = 48;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx   = REG_CENTER_X;
  logic [CFG_W-1:0]        cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    restart   = 1'b0;
  logic                    out_stall = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [PIX_W-1:0] pixel_x, pixel_y;
  logic                    last, finished;
  int                      fail_count, pending;
  int                      steps_sent = 0;
  int                      burst_left = 0;
  int                      idle_cycles = 0;
  int                      stall_age = 0;
  logic [15:0]             stall_pat = '0;

  midpoint_ellipse_rasterizer_top #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .restart_i  (restart),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .pixel_x_o  (pixel_x),
    .pixel_y_o  (pixel_y),
    .last_o     (last),
    .finished_o (finished)
  );

  ellipse_checker #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS),
    .CFG_W      (CFG_W)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .restart_i   (restart),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .last_i      (last),
    .finished_i  (finished),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #CLK_HALF clk = ~clk;

  // rotate a random stall pattern, re-drawn every window, often all free
  always @(negedge clk) begin
    if (stall_age == 0) begin
      stall_age <= STALL_WINDOW;
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    end else begin
      stall_age <= stall_age - 1;
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    out_stall <= stall_pat[0];
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("midpoint_ellipse_rasterizer_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_step(input logic rs);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    steps_sent++;
  endtask

  task automatic run_ellipse(input int steps);
    send_step(1'b1);
    repeat (steps) send_step(1'b0);
  endtask

  // drop valid, drain all predicted beats, then let the block finish its update
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  task automatic set_shape(input logic [CFG_W-1:0] cx, cy, rx, ry);
    settle();
    put_reg(REG_CENTER_X, cx);
    put_reg(REG_CENTER_Y, cy);
    put_reg(REG_RADIUS_X, rx);
    put_reg(REG_RADIUS_Y, ry);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int rx, ry, n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_step(1'b0);
    send_step(1'b0);
    run_ellipse(3);
    set_shape(11'd0, 11'd0, 11'd1023, 11'd1023);
    run_ellipse(3);
    set_shape(11'd2047, 11'd2047, 11'd1023, 11'd0);
    run_ellipse(1);
    set_shape(11'd2047, 11'd0, 11'd0, 11'd3);
    run_ellipse(5);
    set_shape(11'd1024, 11'd1024, 11'd1, 11'd1);
    run_ellipse(3);

    while (steps_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        rx = $urandom_range(0, 2047);
        ry = $urandom_range(0, 2047);
        n  = $urandom_range(2, 8);
      end else begin
        rx = $urandom_range(0, 12);
        ry = $urandom_range(0, 12);
        n  = rx + ry + 1 + $urandom_range(0, 2);
      end
      set_shape(CFG_W'($urandom_range(0, 2047)), CFG_W'($urandom_range(0, 2047)),
                CFG_W'(rx), CFG_W'(ry));
      if ($urandom_range(0, 9) != 0) begin
        send_step(1'b1);
      end
      repeat (n) send_step($urandom_range(0, 11) == 0);
    end

    settle();
    if (fail_count == 0) begin
      $display("midpoint_ellipse_rasterizer_top regression: pass");
    end else begin
      $display("midpoint_ellipse_rasterizer_top regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/mer_pkg.sv
src/mer_ctrl.sv
src/mer_datapath.sv
src/midpoint_ellipse_rasterizer_top.sv
verif/ellipse_checker.sv
verif/testbench.sv
